[rtl/bbpd_pkg.sv]
// bbpd_pkg: widths, codes, constants and shared types of the buck-boost PID drive.
// No dependencies; every other file of the block depends on it.
`timescale 1ns / 1ps

package bbpd_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int MEAS_W     = 16;
    localparam int ERR_W      = 18;
    localparam int COEF_W     = 32;
    localparam int DRIVE_W    = 14;
    localparam int CMP_W      = 13;
    localparam int SAT_W      = 2;
    localparam int PRIOR_W    = DRIVE_W + FRAC_BITS;
    localparam int PROD_W     = COEF_W + ERR_W;
    localparam int ACC_W      = ((PROD_W > PRIOR_W) ? PROD_W : PRIOR_W) + 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int DRIVE_MAX_I = 8399;

    localparam logic [DRIVE_W-1:0] DRIVE_MAX    = DRIVE_W'(DRIVE_MAX_I);
    localparam logic [DRIVE_W-1:0] BUCK_EDGE    = DRIVE_W'(3780);
    localparam logic [DRIVE_W-1:0] MID_EDGE_LO  = DRIVE_W'(3990);
    localparam logic [DRIVE_W-1:0] MID_EDGE_HI  = DRIVE_W'(4410);
    localparam logic [DRIVE_W-1:0] BUCK_OFFSET  = DRIVE_W'(126);
    localparam logic [DRIVE_W-1:0] MID_OFFSET   = DRIVE_W'(3654);
    localparam logic [DRIVE_W-1:0] BOOST_OFFSET = DRIVE_W'(4242);
    localparam logic [CMP_W-1:0]   BUCK_HOLD    = CMP_W'(3864);
    localparam logic [CMP_W-1:0]   BOOST_HOLD   = CMP_W'(294);
    localparam logic [CMP_W-1:0]   BUCK_FULL    = CMP_W'(4199);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SETPOINT         = 2'd0,
        REG_COEF_NOW         = 2'd1,
        REG_COEF_LAST        = 2'd2,
        REG_COEF_BEFORE_LAST = 2'd3
    } cfg_reg_t;

    typedef enum logic [SAT_W-1:0] {
        SAT_NONE = 2'd0,
        SAT_HIGH = 2'd1,
        SAT_LOW  = 2'd2
    } sat_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] coef_now;
        logic signed [COEF_W-1:0] coef_last;
        logic signed [COEF_W-1:0] coef_before_last;
    } pid_coef_t;

    typedef struct packed {
        logic signed [ERR_W-1:0] prior_error;
        logic signed [ERR_W-1:0] older_error;
        logic [PRIOR_W-1:0]      prior_drive;
    } pid_state_t;

    typedef struct packed {
        logic [DRIVE_W-1:0] drive_level;
        logic [CMP_W-1:0]   buck_compare;
        logic [CMP_W-1:0]   boost_compare;
        sat_t               saturated;
    } drive_result_t;

endpackage

[rtl/bbpd_in_if.sv]
// bbpd_in_if: input channel of the buck-boost PID drive, one measurement per item.
// Depends on bbpd_pkg for the field width.
`timescale 1ns / 1ps

interface bbpd_in_if;
    logic                        valid;
    logic                        ready;
    logic [bbpd_pkg::MEAS_W-1:0] measured_sum;

    modport source (output valid, output measured_sum, input ready);
    modport sink   (input valid, input measured_sum, output ready);
endinterface

[rtl/bbpd_out_if.sv]
// bbpd_out_if: result channel of the buck-boost PID drive, drive level and compares.
// Depends on bbpd_pkg for the field widths.
`timescale 1ns / 1ps

interface bbpd_out_if;
    logic                         valid;
    logic                         ready;
    logic [bbpd_pkg::DRIVE_W-1:0] drive_level;
    logic [bbpd_pkg::CMP_W-1:0]   buck_compare;
    logic [bbpd_pkg::CMP_W-1:0]   boost_compare;
    logic [bbpd_pkg::SAT_W-1:0]   saturated;

    modport source (output valid, output drive_level, output buck_compare,
                    output boost_compare, output saturated, input ready);
    modport sink   (input valid, input drive_level, input buck_compare,
                    input boost_compare, input saturated, output ready);
endinterface

[rtl/buck_boost_pid_pwm_drive_top.sv]
// buck_boost_pid_pwm_drive_top: voltage loop of a four-switch buck-boost converter.
// Depends on bbpd_pkg, bbpd_in_if, bbpd_out_if and bbpd_pid_step.
//
//   channel   dir   handshake      payload
//   in_ch     in    valid/ready    measured_sum
//   out_ch    out   valid/ready    drive_level, buck_compare, boost_compare, saturated
//   cfg       in    cfg_we         cfg_index, cfg_data
//
// One item per cycle sustained while out_ch is ready; an accepted item is held in the input register.
// The PID update (three multiplies, sum, clamp, region map) sits between the input
// register and the result register, and the history registers close that loop.
// Reset clears configuration, PID history and both valid flags.
// A stalled result holds in the output register while the input register takes one
// more item; input ready drops only when both are full and the output is stalled.
`timescale 1ns / 1ps

module buck_boost_pid_pwm_drive_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bbpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bbpd_pkg::CFG_DATA_W-1:0] cfg_data,
    bbpd_in_if.sink                         in_ch,
    bbpd_out_if.source                      out_ch
);
    import bbpd_pkg::*;

    logic [MEAS_W-1:0] setpoint_reg;
    pid_coef_t         coef_reg;
    pid_state_t        state_reg;
    pid_state_t        state_next;

    logic              in_valid_reg;
    logic [MEAS_W-1:0] meas_reg;
    logic              out_valid_reg;
    drive_result_t     result_reg;
    drive_result_t     result_next;

    logic              advance;

    assign advance      = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready  = !in_valid_reg || advance;

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.drive_level   = result_reg.drive_level;
    assign out_ch.buck_compare  = result_reg.buck_compare;
    assign out_ch.boost_compare = result_reg.boost_compare;
    assign out_ch.saturated     = result_reg.saturated;

    bbpd_pid_step u_step (
        .setpoint_sum (setpoint_reg),
        .measured_sum (meas_reg),
        .coef         (coef_reg),
        .state        (state_reg),
        .result       (result_next),
        .state_next   (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg  <= '0;
            coef_reg      <= '0;
            state_reg     <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_SETPOINT:         setpoint_reg <= cfg_data[MEAS_W-1:0];
                    REG_COEF_NOW:         coef_reg.coef_now <= $signed(cfg_data[COEF_W-1:0]);
                    REG_COEF_LAST:        coef_reg.coef_last <= $signed(cfg_data[COEF_W-1:0]);
                    REG_COEF_BEFORE_LAST:
                        coef_reg.coef_before_last <= $signed(cfg_data[COEF_W-1:0]);
                    default:              ;
                endcase
            end

            if (in_ch.valid && in_ch.ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            meas_reg <= in_ch.measured_sum;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

endmodule

[rtl/bbpd_pid_step.sv]
// bbpd_pid_step: one incremental PID update with clamp, rollback and region map.
// Purely combinational; depends on bbpd_pkg.
`timescale 1ns / 1ps

module bbpd_pid_step (
    input  logic [bbpd_pkg::MEAS_W-1:0] setpoint_sum,
    input  logic [bbpd_pkg::MEAS_W-1:0] measured_sum,
    input  bbpd_pkg::pid_coef_t         coef,
    input  bbpd_pkg::pid_state_t        state,
    output bbpd_pkg::drive_result_t     result,
    output bbpd_pkg::pid_state_t        state_next
);
    import bbpd_pkg::*;

    localparam logic signed [ACC_W-1:0] ACC_TOP = ACC_W'(DRIVE_MAX_I) << FRAC_BITS;

    logic signed [ERR_W-1:0]  err;
    logic signed [PROD_W-1:0] prod_now;
    logic signed [PROD_W-1:0] prod_last;
    logic signed [PROD_W-1:0] prod_before;
    logic signed [ACC_W-1:0]  acc;
    logic [DRIVE_W-1:0]       drive;

    assign err = $signed({{(ERR_W - MEAS_W){1'b0}}, setpoint_sum})
               - $signed({{(ERR_W - MEAS_W){1'b0}}, measured_sum});

    assign prod_now    = PROD_W'(coef.coef_now) * PROD_W'(err);
    assign prod_last   = PROD_W'(coef.coef_last) * PROD_W'(state.prior_error);
    assign prod_before = PROD_W'(coef.coef_before_last) * PROD_W'(state.older_error);

    assign acc = ACC_W'(prod_now) + ACC_W'(prod_last) + ACC_W'(prod_before)
               + $signed({{(ACC_W - PRIOR_W){1'b0}}, state.prior_drive});

    always_comb
    begin
        state_next = state;
        if (acc > ACC_TOP)
        begin
            drive            = DRIVE_MAX;
            result.saturated = SAT_HIGH;
        end
        else if (acc[ACC_W-1])
        begin
            drive            = '0;
            result.saturated = SAT_LOW;
        end
        else
        begin
            drive                  = acc[FRAC_BITS +: DRIVE_W];
            result.saturated       = SAT_NONE;
            state_next.older_error = state.prior_error;
            state_next.prior_error = err;
            state_next.prior_drive = acc[PRIOR_W-1:0];
        end

        // map drive onto buck and boost legs
        if (drive <= BUCK_EDGE)
        begin
            result.buck_compare  = drive[CMP_W-1:0];
            result.boost_compare = '0;
        end
        else if (drive <= MID_EDGE_LO)
        begin
            result.buck_compare  = CMP_W'(drive - BUCK_OFFSET);
            result.boost_compare = BOOST_HOLD;
        end
        else if (drive <= MID_EDGE_HI)
        begin
            result.buck_compare  = BUCK_HOLD;
            result.boost_compare = CMP_W'(drive - MID_OFFSET);
        end
        else
        begin
            result.buck_compare  = BUCK_FULL;
            result.boost_compare = CMP_W'(drive - BOOST_OFFSET);
        end
        result.drive_level = drive;
    end

endmodule

[tb/testbench.sv]
// testbench: self-checking bench for buck_boost_pid_pwm_drive_top, PID step, clamp and region map.
// Depends on bbpd_pkg, bbpd_in_if, bbpd_out_if and the top module; runs directed rows, then
// fixed and random config phases whose results are checked against a local incremental PID predictor.
`timescale 1ns / 1ps

module testbench;

    import bbpd_pkg::*;

    localparam int PHASES        = 14;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 8;
    localparam int LONG_HOLD     = 60;
    localparam int STALL_LIMIT   = 1000;
    localparam int PLAN_ROWS     = 29;

    typedef enum bit {ROW_WRITE, ROW_MEAS} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        cfg_reg_t    target;
        logic [31:0] value;
        bit          fixed_exp;
        int          drive;
        int          buck;
        int          boost;
        sat_t        sat;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bbpd_in_if  in_if ();
    bbpd_out_if out_if ();

    buck_boost_pid_pwm_drive_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_if),
        .out_ch    (out_if)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    logic [MEAS_W-1:0] target_sum;
    pid_coef_t         gains;
    pid_state_t        history;
    drive_result_t     drive_results_q [$];
    int                fault_count = 0;
    int                hold_requests = 0;
    bit                idle_on = 1'b1;

    plan_row_t plan [PLAN_ROWS] = '{
        '{ROW_MEAS,  REG_SETPOINT,         32'd0,        1'b1, 0,    0,    0,    SAT_NONE},
        '{ROW_MEAS,  REG_SETPOINT,         32'd65535,    1'b1, 0,    0,    0,    SAT_NONE},
        '{ROW_WRITE, REG_COEF_NOW,         32'h0001_0000, 1'b0, 0,   0,    0,    SAT_NONE},
        '{ROW_WRITE, REG_SETPOINT,         32'hFFFF_FFF0, 1'b0, 0,   0,    0,    SAT_NONE},
        '{ROW_MEAS,  REG_SETPOINT,         32'd65520,    1'b1, 0,    0,    0,    SAT_NONE},
        '{ROW_MEAS,  REG_SETPOINT,         32'd61121,    1'b1, 4399, 3864, 745,  SAT_NONE},
        '{ROW_MEAS,  REG_SETPOINT,         32'd61520,    1'b1, 8399, 4199, 4157, SAT_NONE},
        '{ROW_MEAS,  REG_SETPOINT,         32'd65519,    1'b1, 8399, 4199, 4157, SAT_HIGH},
        '{ROW_MEAS,  REG_SETPOINT,         32'd65520,    1'b1, 8399, 4199, 4157, SAT_NONE},
        '{ROW_WRITE, REG_COEF_NOW,         32'h8000_0000, 1'b0, 0,   0,    0,    SAT_NONE},
        '{ROW_MEAS,  REG_SETPOINT,         32'd65519,    1'b1, 0,    0,    0,    SAT_LOW},
        '{ROW_WRITE, REG_COEF_NOW,         32'h7FFF_FFFF, 1'b0, 0,   0,    0,    SAT_NONE},
        '{ROW_MEAS,  REG_SETPOINT,         32'd0,        1'b1, 8399, 4199, 4157, SAT_HIGH},
        '{ROW_WRITE, REG_COEF_NOW,         32'h0001_0000, 1'b0, 0,   0,    0,    SAT_NONE},
        '{ROW_WRITE, REG_SETPOINT,         32'h0000_0000, 1'b0, 0,   0,    0,    SAT_NONE},
        '{ROW_MEAS,  REG_SETPOINT,         32'd3988,     1'b0, 0,    0,    0,    SAT_NONE},
        '{ROW_MEAS,  REG_SETPOINT,         32'd1,        1'b0, 0,    0,    0,    SAT_NONE},
        '{ROW_MEAS,  REG_SETPOINT,         32'd419,      1'b0, 0,    0,    0,    SAT_NONE},
        '{ROW_MEAS,  REG_SETPOINT,         32'd1,        1'b0, 0,    0,    0,    SAT_NONE},
        '{ROW_MEAS,  REG_SETPOINT,         32'd209,      1'b0, 0,    0,    0,    SAT_NONE},
        '{ROW_MEAS,  REG_SETPOINT,         32'd1,        1'b0, 0,    0,    0,    SAT_NONE},
        '{ROW_WRITE, REG_COEF_NOW,         32'h0000_8001, 1'b0, 0,   0,    0,    SAT_NONE},
        '{ROW_MEAS,  REG_SETPOINT,         32'd3,        1'b0, 0,    0,    0,    SAT_NONE},
        '{ROW_WRITE, REG_COEF_LAST,        32'hFFFF_8000, 1'b0, 0,   0,    0,    SAT_NONE},
        '{ROW_WRITE, REG_COEF_BEFORE_LAST, 32'h0002_4000, 1'b0, 0,   0,    0,    SAT_NONE},
        '{ROW_MEAS,  REG_SETPOINT,         32'd100,      1'b0, 0,    0,    0,    SAT_NONE},
        '{ROW_MEAS,  REG_SETPOINT,         32'd50,       1'b0, 0,    0,    0,    SAT_NONE},
        '{ROW_MEAS,  REG_SETPOINT,         32'd0,        1'b0, 0,    0,    0,    SAT_NONE},
        '{ROW_MEAS,  REG_SETPOINT,         32'd65535,    1'b0, 0,    0,    0,    SAT_NONE}
    };

    function automatic drive_result_t advance_pid(input logic [MEAS_W-1:0] meas);
        longint             err;
        longint             acc;
        longint             top;
        logic [DRIVE_W-1:0] lvl;
        drive_result_t      res;
        err = longint'(target_sum) - longint'(meas);
        acc = longint'($signed(gains.coef_now)) * err
            + longint'($signed(gains.coef_last)) * longint'($signed(history.prior_error))
            + longint'($signed(gains.coef_before_last)) * longint'($signed(history.older_error))
            + longint'(history.prior_drive);
        top = longint'(DRIVE_MAX_I) <<< FRAC_BITS;
        if (acc > top)
        begin
            lvl = DRIVE_MAX;
            res.saturated = SAT_HIGH;
        end
        else if (acc < 0)
        begin
            lvl = '0;
            res.saturated = SAT_LOW;
        end
        else
        begin
            lvl = DRIVE_W'(acc >>> FRAC_BITS);
            res.saturated = SAT_NONE;
            history.older_error = history.prior_error;
            history.prior_error = ERR_W'(err);
            history.prior_drive = PRIOR_W'(acc);
        end
        res.drive_level = lvl;
        if (lvl <= BUCK_EDGE)
        begin
            res.buck_compare  = CMP_W'(lvl);
            res.boost_compare = '0;
        end
        else if (lvl <= MID_EDGE_LO)
        begin
            res.buck_compare  = CMP_W'(lvl - BUCK_OFFSET);
            res.boost_compare = BOOST_HOLD;
        end
        else if (lvl <= MID_EDGE_HI)
        begin
            res.buck_compare  = BUCK_HOLD;
            res.boost_compare = CMP_W'(lvl - MID_OFFSET);
        end
        else
        begin
            res.buck_compare  = BUCK_FULL;
            res.boost_compare = CMP_W'(lvl - BOOST_OFFSET);
        end
        return res;
    endfunction

    function automatic logic [COEF_W-1:0] random_gain(input int unsigned span);
        int unsigned mag;
        mag = $urandom_range(0, span);
        return ($urandom_range(0, 1) == 1) ? COEF_W'(-mag) : COEF_W'(mag);
    endfunction

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_SETPOINT:         target_sum = val[MEAS_W-1:0];
            REG_COEF_NOW:         gains.coef_now = val;
            REG_COEF_LAST:        gains.coef_last = val;
            REG_COEF_BEFORE_LAST: gains.coef_before_last = val;
            default:              ;
        endcase
        @(posedge clk);
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (drive_results_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_measurement(input logic [MEAS_W-1:0] meas, input bit fixed_exp,
                                    input drive_result_t fixed_res);
        drive_result_t predicted;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_if.valid        <= 1'b1;
        in_if.measured_sum <= meas;
        @(posedge clk);
        while (!in_if.ready)
            @(posedge clk);
        predicted = advance_pid(meas);
        drive_results_q.push_back(fixed_exp ? fixed_res : predicted);
    endtask

    initial
    begin
        plan_row_t         row;
        drive_result_t     lit;
        logic [31:0]       word;
        logic [MEAS_W-1:0] meas;
        int                count;
        int                t;
        in_if.valid        <= 1'b0;
        in_if.measured_sum <= '0;
        cfg_we             <= 1'b0;
        cfg_index          <= REG_SETPOINT;
        cfg_data           <= '0;
        target_sum = '0;
        gains      = '0;
        history    = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < PLAN_ROWS; i++)
        begin
            row = plan[i];
            if (row.kind == ROW_WRITE)
            begin
                wait_drained();
                write_reg(row.target, row.value);
            end
            else
            begin
                lit.drive_level   = DRIVE_W'(row.drive);
                lit.buck_compare  = CMP_W'(row.buck);
                lit.boost_compare = CMP_W'(row.boost);
                lit.saturated     = row.sat;
                send_measurement(MEAS_W'(row.value), row.fixed_exp, lit);
            end
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_drained();
            idle_on <= (ph != 10 && ph < 12);
            if (ph == 0)
            begin
                write_reg(REG_SETPOINT, 32'h0000_FFFF);
                write_reg(REG_COEF_NOW, 32'h8000_0000);
                write_reg(REG_COEF_LAST, 32'h7FFF_FFFF);
                write_reg(REG_COEF_BEFORE_LAST, 32'h8000_0000);
            end
            else if (ph == 1)
            begin
                write_reg(REG_SETPOINT, 32'h0000_0000);
                write_reg(REG_COEF_NOW, 32'h7FFF_FFFF);
                write_reg(REG_COEF_LAST, 32'h7FFF_FFFF);
                write_reg(REG_COEF_BEFORE_LAST, 32'h7FFF_FFFF);
            end
            else if (ph == 9)
            begin
                write_reg(REG_COEF_NOW, $urandom());
                write_reg(REG_COEF_LAST, $urandom());
                write_reg(REG_COEF_BEFORE_LAST, $urandom());
            end
            else
            begin
                if (ph == 2 || $urandom_range(0, 3) != 0)
                begin
                    word = $urandom();
                    word[MEAS_W-1:0] = MEAS_W'($urandom_range(0, 65520));
                    write_reg(REG_SETPOINT, word);
                end
                if (ph == 2 || $urandom_range(0, 3) != 0)
                    write_reg(REG_COEF_NOW, random_gain(1 << 18));
                if (ph == 2 || $urandom_range(0, 3) != 0)
                    write_reg(REG_COEF_LAST, random_gain(1 << 17));
                if (ph == 2 || $urandom_range(0, 3) != 0)
                    write_reg(REG_COEF_BEFORE_LAST, random_gain(1 << 16));
            end
            // stall the result side for a long stretch while items keep coming
            if (ph == 4)
                hold_requests <= hold_requests + 1;
            count = (ph < 2) ? 12 : 34;
            for (int n = 0; n < count; n++)
            begin
                if (ph == 7 && n == 17)
                    wait_drained();
                if (ph < 2 || $urandom_range(0, 4) == 0)
                    meas = MEAS_W'($urandom());
                else
                begin
                    t = int'(target_sum) + int'($urandom_range(0, 600)) - 300;
                    meas = MEAS_W'((t < 0) ? 0 : (t > 65535) ? 65535 : t);
                end
                send_measurement(meas, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fault_count == 0 && drive_results_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        drive_result_t want;
        int            gap_left;
        int            hold_left;
        int            holds_done;
        gap_left   = 0;
        hold_left  = 0;
        holds_done = 0;
        out_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_if.valid && out_if.ready)
            begin
                if (drive_results_q.size() == 0)
                begin
                    if (fault_count < 10)
                        $display("unexpected result: drive %0d buck %0d boost %0d sat %0d",
                                 out_if.drive_level, out_if.buck_compare,
                                 out_if.boost_compare, out_if.saturated);
                    fault_count++;
                end
                else
                begin
                    want = drive_results_q.pop_front();
                    if (out_if.drive_level !== want.drive_level
                        || out_if.buck_compare !== want.buck_compare
                        || out_if.boost_compare !== want.boost_compare
                        || out_if.saturated !== want.saturated)
                    begin
                        if (fault_count < 10)
                            $display("mismatch (exp/got): drive %0d/%0d buck %0d/%0d boost %0d/%0d sat %0d/%0d",
                                     want.drive_level, out_if.drive_level,
                                     want.buck_compare, out_if.buck_compare,
                                     want.boost_compare, out_if.boost_compare,
                                     want.saturated, out_if.saturated);
                        fault_count++;
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_if.ready <= 1'b0;
            end
            else if (holds_done != hold_requests)
            begin
                holds_done++;
                hold_left = LONG_HOLD - 1;
                out_if.ready <= 1'b0;
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                out_if.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                gap_left = int'($urandom_range(1, 7)) - 1;
                out_if.ready <= 1'b0;
            end
            else
                out_if.ready <= 1'b1;
        end
    end

    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

endmodule

[files.f]
rtl/bbpd_pkg.sv
rtl/bbpd_in_if.sv
rtl/bbpd_out_if.sv
rtl/bbpd_pid_step.sv
rtl/buck_boost_pid_pwm_drive_top.sv
tb/testbench.sv
